### hw/rtl/acab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_pkg: shared types and constants for the record converter
// Payload structs for both channels, the parser-to-emitter command and the
// status codes reported with the final result of a record.
// ----------------------------------------------------------------------------
package acab_pkg;

    localparam int DEFAULT_MAX_SETS = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] START_CODE_LEN  = 3'd4;
    localparam logic [7:0] START_CODE_TAIL = 8'h01;
    localparam logic [2:0] LEN_SIZE_RESET  = 3'd4;
    localparam logic [2:0] LEN_SIZE_BAD    = 3'd3;
    localparam logic [7:0] VERSION_ONE     = 8'h01;
    localparam logic [4:0] SPS_COUNT_MASK  = 5'h1F;
    localparam logic [2:0] HDR_SEEN_MAX    = 3'd7;

    typedef enum logic [1:0] {
        ST_CONVERTED   = 2'd0,
        ST_NO_SETS     = 2'd1,
        ST_RAW_HEADER  = 2'd2,
        ST_RAW_NO_HDR  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_record;
        logic [1:0] status;
        logic [2:0] nal_length_size;
        logic [5:0] sets_found;
    } out_item_t;

    // One queued command: start code, one data byte, and/or the end status.
    typedef struct packed {
        logic       is_sc;
        logic       is_data;
        logic       has_end;
        logic [7:0] data;
        status_t    status;
        logic [2:0] nls;
        logic [5:0] sets;
    } cmd_t;

endpackage

### hw/rtl/acab_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_front: record parser
// Walks the configuration record one byte per request and turns each byte
// into at most one command for the emitter.
// ----------------------------------------------------------------------------
module acab_front #(
    parameter int MAX_SETS = acab_pkg::DEFAULT_MAX_SETS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  acab_pkg::in_item_t in_item,
    input  logic              q_full,
    output logic              push,
    output acab_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        PH_VERSION, PH_PROFILE, PH_COMPAT, PH_LEVEL, PH_LENSIZE, PH_SPSCOUNT,
        PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_PPSCOUNT, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  hbs_reg, hbs_next;
    logic        fbz_reg, fbz_next;
    logic [7:0]  sets_left_reg, sets_left_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  len_high_reg, len_high_next;
    logic [5:0]  set_total_reg, set_total_next;
    logic [2:0]  len_size_reg, len_size_next;
    logic        failed_reg, failed_next;
    logic        in_pps_reg, in_pps_next;

    logic        accept;
    logic [7:0]  b;
    logic [7:0]  sets_dec;
    logic [15:0] bytes_dec;
    logic [15:0] len;
    phase_t      finish_phase;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign b        = in_item.in_byte;
    assign sets_dec = sets_left_reg - 8'd1;
    assign bytes_dec = bytes_left_reg - 16'd1;
    assign len      = {len_high_reg, b};

    always_comb begin
        if (sets_dec != 8'd0) begin
            finish_phase = PH_LEN_HI;
        end else if (in_pps_reg) begin
            finish_phase = PH_DONE;
        end else begin
            finish_phase = PH_PPSCOUNT;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        hbs_next        = hbs_reg;
        fbz_next        = fbz_reg;
        sets_left_next  = sets_left_reg;
        bytes_left_next = bytes_left_reg;
        len_high_next   = len_high_reg;
        set_total_next  = set_total_reg;
        len_size_next   = len_size_reg;
        failed_next     = failed_reg;
        in_pps_next     = in_pps_reg;
        cmd             = '0;
        push            = 1'b0;

        if (accept) begin
            if (hbs_reg < acab_pkg::HDR_SEEN_MAX) begin
                hbs_next = hbs_reg + 3'd1;
            end
            if (!failed_reg) begin
                case (phase_reg)
                    PH_VERSION: begin
                        fbz_next = (b == 8'd0);
                        if (b != acab_pkg::VERSION_ONE) begin
                            failed_next = 1'b1;
                        end else begin
                            phase_next = PH_PROFILE;
                        end
                    end
                    PH_PROFILE: phase_next = PH_COMPAT;
                    PH_COMPAT:  phase_next = PH_LEVEL;
                    PH_LEVEL:   phase_next = PH_LENSIZE;
                    PH_LENSIZE: begin
                        len_size_next = {1'b0, b[1:0]} + 3'd1;
                        if (len_size_next == acab_pkg::LEN_SIZE_BAD) begin
                            failed_next = 1'b1;
                        end else begin
                            phase_next = PH_SPSCOUNT;
                        end
                    end
                    PH_SPSCOUNT: begin
                        in_pps_next    = 1'b0;
                        sets_left_next = {3'b000, b[4:0] & acab_pkg::SPS_COUNT_MASK};
                        phase_next     = (sets_left_next == 8'd0) ? PH_PPSCOUNT : PH_LEN_HI;
                    end
                    PH_PPSCOUNT: begin
                        in_pps_next    = 1'b1;
                        sets_left_next = b;
                        phase_next     = (b == 8'd0) ? PH_DONE : PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        len_high_next = b;
                        phase_next    = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        if (set_total_reg >= 6'(MAX_SETS)) begin
                            failed_next = 1'b1;
                        end else begin
                            set_total_next = set_total_reg + 6'd1;
                            cmd.is_sc      = 1'b1;
                            if (len == 16'd0) begin
                                sets_left_next = sets_dec;
                                phase_next     = finish_phase;
                            end else begin
                                bytes_left_next = len;
                                phase_next      = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        cmd.is_data     = 1'b1;
                        cmd.data        = b;
                        bytes_left_next = bytes_dec;
                        if (bytes_dec == 16'd0) begin
                            sets_left_next = sets_dec;
                            phase_next     = finish_phase;
                        end
                    end
                    default: ;
                endcase
            end

            cmd.nls  = len_size_next;
            cmd.sets = set_total_next;

            if (in_item.is_last) begin
                cmd.has_end = 1'b1;
                if (!failed_next && phase_next == PH_DONE) begin
                    cmd.status = (set_total_next == 6'd0) ? acab_pkg::ST_NO_SETS
                                                          : acab_pkg::ST_CONVERTED;
                end else if (hbs_next == acab_pkg::HDR_SEEN_MAX && fbz_next) begin
                    cmd.status = acab_pkg::ST_RAW_NO_HDR;
                end else begin
                    cmd.status = acab_pkg::ST_RAW_HEADER;
                end
                // start the next record from scratch
                phase_next      = PH_VERSION;
                hbs_next        = '0;
                fbz_next        = 1'b0;
                sets_left_next  = '0;
                bytes_left_next = '0;
                len_high_next   = '0;
                set_total_next  = '0;
                len_size_next   = acab_pkg::LEN_SIZE_RESET;
                failed_next     = 1'b0;
                in_pps_next     = 1'b0;
            end
            push = cmd.is_sc || cmd.is_data || cmd.has_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_VERSION;
            hbs_reg        <= '0;
            fbz_reg        <= 1'b0;
            sets_left_reg  <= '0;
            bytes_left_reg <= '0;
            len_high_reg   <= '0;
            set_total_reg  <= '0;
            len_size_reg   <= acab_pkg::LEN_SIZE_RESET;
            failed_reg     <= 1'b0;
            in_pps_reg     <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hbs_reg        <= hbs_next;
            fbz_reg        <= fbz_next;
            sets_left_reg  <= sets_left_next;
            bytes_left_reg <= bytes_left_next;
            len_high_reg   <= len_high_next;
            set_total_reg  <= set_total_next;
            len_size_reg   <= len_size_next;
            failed_reg     <= failed_next;
            in_pps_reg     <= in_pps_next;
        end
    end

endmodule

### hw/rtl/acab_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_queue: command queue
// Small first-in first-out store between parser and emitter.
// ----------------------------------------------------------------------------
module acab_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  acab_pkg::cmd_t push_cmd,
    input  logic           pop,
    output acab_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);

    acab_pkg::cmd_t                mem [acab_pkg::QUEUE_DEPTH];
    logic [acab_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [acab_pkg::QUEUE_AW:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (acab_pkg::QUEUE_AW + 1)'(acab_pkg::QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (acab_pkg::QUEUE_AW)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (acab_pkg::QUEUE_AW)'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (acab_pkg::QUEUE_AW + 1)'(1);
                2'b01:   count_reg <= count_reg - (acab_pkg::QUEUE_AW + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### hw/rtl/acab_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_back: result emitter
// Expands each queued command into start code bytes, a data byte and the end
// status, one result per cycle into the output register while fed, unstalled.
// ----------------------------------------------------------------------------
module acab_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  acab_pkg::cmd_t      head,
    input  logic                q_empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output acab_pkg::out_item_t m_item
);

    logic [2:0]          step_reg;
    logic                valid_reg;
    acab_pkg::out_item_t item_reg, item_next;
    logic [2:0]          n_bytes, n_total;
    logic                load, last_step;

    assign n_bytes   = head.is_sc ? acab_pkg::START_CODE_LEN : {2'b00, head.is_data};
    assign n_total   = n_bytes + {2'b00, head.has_end};
    assign last_step = (step_reg == n_total - 3'd1);
    assign load      = !q_empty && (!valid_reg || m_ready);
    assign pop       = load && last_step;

    always_comb begin
        item_next                 = '0;
        item_next.nal_length_size = head.nls;
        item_next.sets_found      = head.sets;
        if (step_reg < n_bytes) begin
            item_next.byte_valid = 1'b1;
            if (head.is_sc) begin
                item_next.out_byte = (step_reg == acab_pkg::START_CODE_LEN - 3'd1)
                                   ? acab_pkg::START_CODE_TAIL : 8'h00;
            end else begin
                item_next.out_byte = head.data;
            end
        end else begin
            item_next.end_of_record = 1'b1;
            item_next.status        = head.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                step_reg  <= last_step ? 3'd0 : step_reg + 3'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

### hw/rtl/avcc_to_annexb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_unit: decoder configuration record to Annex B
// Parses a decoder configuration record byte by byte and emits each SPS and
// PPS as a start code followed by its bytes, then a status on the last byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_item  (in_byte, is_last)
//  m_      | out       | m_valid / m_ready  | m_item  (out_byte .. sets_found)
//
//  One request is taken per cycle while the command queue has room.
//  A data byte gives one output result; a set header gives four (the start
//  code), the last request one more for the status; the emitter sets the rate.
//  The four-entry queue absorbs start-code bursts, so data runs at one byte per
//  cycle if unstalled. Reset (aresetn low, synchronous) empties queue and
//  output. A stalled m_ready holds the output register; s_ready drops once full.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter_unit #(
    parameter int MAX_SETS = acab_pkg::DEFAULT_MAX_SETS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  acab_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output acab_pkg::out_item_t m_item
);

    // parser to queue
    acab_pkg::cmd_t push_cmd;
    logic           push;
    // queue to emitter
    acab_pkg::cmd_t head;
    logic           q_empty, q_full, pop;

    // Front: classify each request, keep the record walk state.
    acab_front #(
        .MAX_SETS(MAX_SETS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_item),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Hold commands so parser and emitter stall independently.
    acab_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Back: expand commands into output bytes and the final status.
    acab_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

### hw/rtl/acab_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acab_checker: port-level checks for the converter
// Watches the result channel for handshake and result-shape errors.
// ----------------------------------------------------------------------------
module acab_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input acab_pkg::out_item_t m_item
);

    // Hold a stalled result.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    // A status-only result closes the record, and only it does.
    a_end_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.byte_valid != m_item.end_of_record))
        else $error("byte_valid and end_of_record disagree");

    // Data results carry no status.
    a_data_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.byte_valid |-> m_item.status == acab_pkg::ST_CONVERTED)
        else $error("status set on a data result");

    // Length size is always 1 to 4.
    a_nls_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.nal_length_size != 3'd0 && m_item.nal_length_size <= 3'd4))
        else $error("nal_length_size out of range");

endmodule

bind avcc_to_annexb_converter_unit acab_checker u_acab_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
